// ===== hw/rtl/hex_record_encoder_macros.svh =====
// Assertion macros used by the hex record encoder datapath.
`ifndef HEX_RECORD_ENCODER_MACROS_SVH
`define HEX_RECORD_ENCODER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HRE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HRE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/hre_pkg.sv =====
// Types, constants and the microcode ROM of the hex record encoder.
package hre_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_LANE_MASK    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ADDR_OFFSET  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_ADDR   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_ENABLE = 3'd3;

   localparam logic FUNC_DATA  = 1'b0;
   localparam logic FUNC_FLUSH = 1'b1;

   localparam int TYPE_W = 2;
   localparam logic [TYPE_W-1:0] REC_DATA  = 2'd0;
   localparam logic [TYPE_W-1:0] REC_EOF   = 2'd1;
   localparam logic [TYPE_W-1:0] REC_START = 2'd3;

   localparam int STEP_W = 3;
   localparam logic [STEP_W-1:0] STEP_COUNT   = 3'd0;
   localparam logic [STEP_W-1:0] STEP_ADDR_HI = 3'd1;
   localparam logic [STEP_W-1:0] STEP_ADDR_LO = 3'd2;
   localparam logic [STEP_W-1:0] STEP_TYPE    = 3'd3;
   localparam logic [STEP_W-1:0] STEP_DATA    = 3'd4;
   localparam logic [STEP_W-1:0] STEP_SUM     = 3'd5;

   typedef enum logic [2:0] {
      SRC_COUNT,
      SRC_ADDR_HI,
      SRC_ADDR_LO,
      SRC_TYPE,
      SRC_DATA,
      SRC_SUM
   } src_type;

   typedef enum logic [1:0] {
      COND_NONE,
      COND_HAS_DATA,
      COND_MORE_DATA,
      COND_CHAIN
   } cond_type;

   typedef struct packed {
      src_type          src;
      logic             rec_begin;
      logic             rec_finish;
      cond_type         cond;
      logic [STEP_W-1:0] next;
      logic [STEP_W-1:0] target;
   } ucode_type;

   typedef struct packed {
      logic      busy;
      ucode_type uc;
   } seq_ctrl_type;

   typedef struct packed {
      logic start;
      logic adv;
      logic has_data;
      logic more_data;
      logic chain;
   } dp_status_type;

   function automatic ucode_type ucode_rom(input logic [STEP_W-1:0] step);
      ucode_type word;
      unique case (step)
         STEP_COUNT:   word = '{SRC_COUNT, 1'b1, 1'b0, COND_NONE, STEP_ADDR_HI, STEP_COUNT};
         STEP_ADDR_HI: word = '{SRC_ADDR_HI, 1'b0, 1'b0, COND_NONE, STEP_ADDR_LO, STEP_COUNT};
         STEP_ADDR_LO: word = '{SRC_ADDR_LO, 1'b0, 1'b0, COND_NONE, STEP_TYPE, STEP_COUNT};
         STEP_TYPE:    word = '{SRC_TYPE, 1'b0, 1'b0, COND_HAS_DATA, STEP_SUM, STEP_DATA};
         STEP_DATA:    word = '{SRC_DATA, 1'b0, 1'b0, COND_MORE_DATA, STEP_SUM, STEP_DATA};
         STEP_SUM:     word = '{SRC_SUM, 1'b0, 1'b1, COND_CHAIN, STEP_COUNT, STEP_COUNT};
         default:      word = '{SRC_COUNT, 1'b1, 1'b0, COND_NONE, STEP_ADDR_HI, STEP_COUNT};
      endcase
      return word;
   endfunction

   function automatic logic [6:0] hex_char(input logic [3:0] nib);
      return (nib < 4'd10) ? (7'h30 + {3'b000, nib}) : (7'h37 + {3'b000, nib});
   endfunction

endpackage

// ===== hw/rtl/hre_if.sv =====
// Request and response channel interfaces of the hex record encoder.
interface hre_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [7:0] data_byte;

   modport source (output valid, output func, output data_byte, input ready);
   modport sink (input valid, input func, input data_byte, output ready);
endinterface

interface hre_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] record_byte;
   logic [6:0] hex_high_char;
   logic [6:0] hex_low_char;
   logic       record_begin;
   logic       record_finish;
   logic       last;

   modport source (output valid, output record_byte, output hex_high_char,
                   output hex_low_char, output record_begin, output record_finish,
                   output last, input ready);
   modport sink (input valid, input record_byte, input hex_high_char,
                 input hex_low_char, input record_begin, input record_finish,
                 input last, output ready);
endinterface

// ===== hw/rtl/hre_ram.sv =====
// Generic simple dual-port RAM with registered read data.
module hre_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/hre_seq.sv =====
// Microcode sequencer: step counter, control ROM lookup and jump logic.
module hre_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  hre_pkg::dp_status_type status,
   output hre_pkg::seq_ctrl_type  ctrl
);
   import hre_pkg::*;

   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   ucode_type         uc;

   assign uc        = ucode_rom(step_ff);
   assign ctrl.busy = busy_ff;
   assign ctrl.uc   = uc;

   always_comb begin
      step_in = step_ff;
      busy_in = busy_ff;
      if (status.start) begin
         step_in = STEP_COUNT;
         busy_in = 1'b1;
      end else if (status.adv) begin
         unique case (uc.cond)
            COND_NONE:      step_in = uc.next;
            COND_HAS_DATA:  step_in = status.has_data ? uc.target : uc.next;
            COND_MORE_DATA: step_in = status.more_data ? uc.target : uc.next;
            COND_CHAIN: begin
               step_in = uc.target;
               busy_in = status.chain;
            end
            default:        step_in = STEP_COUNT;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_COUNT;
         busy_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         busy_ff <= busy_in;
      end
   end

endmodule

// ===== hw/rtl/hre_dpath.sv =====
// Datapath: registers, stream state, record buffer and response register.
module hre_dpath #(
   parameter int RECORD_LENGTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   hre_req_if.sink                              req,
   hre_rsp_if.source                            rsp,
   input  logic                                 csr_write_en,
   input  logic [hre_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [hre_pkg::CSR_DATA_W-1:0]       csr_data,
   input  hre_pkg::seq_ctrl_type                ctrl,
   output hre_pkg::dp_status_type               status
);
   import hre_pkg::*;
   `include "hex_record_encoder_macros.svh"

   localparam int CNT_W  = $clog2(RECORD_LENGTH + 1);
   localparam int ADDR_W = (RECORD_LENGTH > 1) ? $clog2(RECORD_LENGTH) : 1;
   localparam logic [CNT_W-1:0] REC_LEN_C    = CNT_W'(RECORD_LENGTH);
   localparam logic [15:0]      REC_LEN_ADDR = 16'(RECORD_LENGTH);

   logic [3:0]        lane_mask_ff;
   logic [15:0]       addr_offset_ff;
   logic [15:0]       start_addr_ff;
   logic              start_en_ff;

   logic [1:0]        lane_pos_ff, lane_pos_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [15:0]       rec_base_ff, rec_base_in;

   logic [CNT_W-1:0]  rec_count_ff, rec_count_in;
   logic [15:0]       rec_addr_ff, rec_addr_in;
   logic [TYPE_W-1:0] rec_type_ff, rec_type_in;
   logic [CNT_W-1:0]  data_idx_ff, data_idx_in;
   logic [7:0]        sum_ff, sum_in;
   logic              pend_start_ff, pend_start_in;
   logic              pend_eof_ff, pend_eof_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_byte_ff, rsp_byte_in;
   logic              rsp_begin_ff, rsp_begin_in;
   logic              rsp_finish_ff, rsp_finish_in;
   logic              rsp_last_ff, rsp_last_in;

   logic [3:0]        mask_eff;
   logic              accept;
   logic              keep;
   logic [CNT_W-1:0]  fill_inc;
   logic              adv;
   logic              chain;
   logic              start;
   logic              ram_we;
   logic [7:0]        ram_rdata;
   logic [7:0]        out_byte;

   assign mask_eff = (lane_mask_ff == 4'd0) ? 4'hF : lane_mask_ff;
   assign accept   = req.valid && !ctrl.busy;
   assign keep     = mask_eff[lane_pos_ff];
   assign fill_inc = fill_ff + CNT_W'(1);
   assign adv      = ctrl.busy && (!rsp_valid_ff || rsp.ready);
   assign chain    = pend_start_ff || pend_eof_ff;

   assign req.ready = !ctrl.busy;

   assign status.start     = start;
   assign status.adv       = adv;
   assign status.has_data  = (rec_type_ff == REC_DATA);
   assign status.more_data = ((data_idx_ff + CNT_W'(1)) != rec_count_ff);
   assign status.chain     = chain;

   always_comb begin
      unique case (ctrl.uc.src)
         SRC_COUNT:   out_byte = 8'(rec_count_ff);
         SRC_ADDR_HI: out_byte = rec_addr_ff[15:8];
         SRC_ADDR_LO: out_byte = rec_addr_ff[7:0];
         SRC_TYPE:    out_byte = 8'(rec_type_ff);
         SRC_DATA:    out_byte = ram_rdata;
         SRC_SUM:     out_byte = 8'd0 - sum_ff;
         default:     out_byte = 8'd0;
      endcase
   end

   always_comb begin
      lane_pos_in   = lane_pos_ff;
      fill_in       = fill_ff;
      rec_base_in   = rec_base_ff;
      rec_count_in  = rec_count_ff;
      rec_addr_in   = rec_addr_ff;
      rec_type_in   = rec_type_ff;
      data_idx_in   = data_idx_ff;
      sum_in        = sum_ff;
      pend_start_in = pend_start_ff;
      pend_eof_in   = pend_eof_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_begin_in  = rsp_begin_ff;
      rsp_finish_in = rsp_finish_ff;
      rsp_last_in   = rsp_last_ff;
      start         = 1'b0;
      ram_we        = 1'b0;

      if (accept) begin
         if (req.func == FUNC_DATA) begin
            lane_pos_in = lane_pos_ff + 2'd1;
            if (keep) begin
               ram_we = 1'b1;
               if (fill_inc == REC_LEN_C) begin
                  start         = 1'b1;
                  rec_count_in  = REC_LEN_C;
                  rec_addr_in   = rec_base_ff + addr_offset_ff;
                  rec_type_in   = REC_DATA;
                  data_idx_in   = '0;
                  rec_base_in   = rec_base_ff + REC_LEN_ADDR;
                  fill_in       = '0;
                  pend_start_in = 1'b0;
                  pend_eof_in   = 1'b0;
               end else begin
                  fill_in = fill_inc;
               end
            end
         end else begin
            start       = 1'b1;
            lane_pos_in = 2'd0;
            fill_in     = '0;
            rec_base_in = 16'd0;
            data_idx_in = '0;
            if (fill_ff != '0) begin
               rec_count_in  = fill_ff;
               rec_addr_in   = rec_base_ff + addr_offset_ff;
               rec_type_in   = REC_DATA;
               pend_start_in = start_en_ff;
               pend_eof_in   = 1'b1;
            end else if (start_en_ff) begin
               rec_count_in  = '0;
               rec_addr_in   = start_addr_ff;
               rec_type_in   = REC_START;
               pend_start_in = 1'b0;
               pend_eof_in   = 1'b1;
            end else begin
               rec_count_in  = '0;
               rec_addr_in   = 16'd0;
               rec_type_in   = REC_EOF;
               pend_start_in = 1'b0;
               pend_eof_in   = 1'b0;
            end
         end
      end

      if (adv) begin
         rsp_valid_in  = 1'b1;
         rsp_byte_in   = out_byte;
         rsp_begin_in  = ctrl.uc.rec_begin;
         rsp_finish_in = ctrl.uc.rec_finish;
         rsp_last_in   = ctrl.uc.rec_finish && !chain;
         sum_in        = ctrl.uc.rec_begin ? out_byte : (sum_ff + out_byte);
         if (ctrl.uc.src == SRC_DATA) begin
            data_idx_in = data_idx_ff + CNT_W'(1);
         end
         if (ctrl.uc.rec_finish && chain) begin
            rec_count_in = '0;
            data_idx_in  = '0;
            if (pend_start_ff) begin
               rec_addr_in   = start_addr_ff;
               rec_type_in   = REC_START;
               pend_start_in = 1'b0;
            end else begin
               rec_addr_in = 16'd0;
               rec_type_in = REC_EOF;
               pend_eof_in = 1'b0;
            end
         end
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   hre_ram #(
      .WIDTH (8),
      .DEPTH (RECORD_LENGTH)
   ) u_buffer (
      .clock (clock),
      .we    (ram_we),
      .waddr (fill_ff[ADDR_W-1:0]),
      .wdata (req.data_byte),
      .raddr (data_idx_in[ADDR_W-1:0]),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_mask_ff   <= 4'hF;
         addr_offset_ff <= 16'd0;
         start_addr_ff  <= 16'd0;
         start_en_ff    <= 1'b0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_LANE_MASK:    lane_mask_ff   <= csr_data[3:0];
            CSR_ADDR_OFFSET:  addr_offset_ff <= csr_data;
            CSR_START_ADDR:   start_addr_ff  <= csr_data;
            CSR_START_ENABLE: start_en_ff    <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_pos_ff   <= 2'd0;
         fill_ff       <= '0;
         rec_base_ff   <= 16'd0;
         pend_start_ff <= 1'b0;
         pend_eof_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         lane_pos_ff   <= lane_pos_in;
         fill_ff       <= fill_in;
         rec_base_ff   <= rec_base_in;
         pend_start_ff <= pend_start_in;
         pend_eof_ff   <= pend_eof_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rec_count_ff  <= rec_count_in;
      rec_addr_ff   <= rec_addr_in;
      rec_type_ff   <= rec_type_in;
      data_idx_ff   <= data_idx_in;
      sum_ff        <= sum_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_begin_ff  <= rsp_begin_in;
      rsp_finish_ff <= rsp_finish_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.record_byte   = rsp_byte_ff;
   assign rsp.hex_high_char = hex_char(rsp_byte_ff[7:4]);
   assign rsp.hex_low_char  = hex_char(rsp_byte_ff[3:0]);
   assign rsp.record_begin  = rsp_begin_ff;
   assign rsp.record_finish = rsp_finish_ff;
   assign rsp.last          = rsp_last_ff;

   `HRE_ASSERT_NOW(a_fill_below_len, clock, reset, 1'b1, fill_ff < REC_LEN_C,
      "Buffer fill count reached the record length.")
   `HRE_ASSERT_NOW(a_data_in_range, clock, reset, ctrl.busy && ctrl.uc.src == SRC_DATA,
      data_idx_ff < rec_count_ff, "Data byte index ran past the record count.")
   `HRE_ASSERT_NEXT(a_last_ends_busy, clock, reset, adv && rsp_last_in, !ctrl.busy,
      "Sequencer stayed busy after the final response of a request.")
   `HRE_ASSERT_NOW(a_empty_not_data, clock, reset, adv && ctrl.uc.src == SRC_TYPE &&
      rec_type_ff != REC_DATA, rec_count_ff == '0,
      "Start or end record carries a nonzero count.")

endmodule

// ===== hw/rtl/hex_record_encoder.sv =====
// Top level of the hex record encoder.
//
// Requests carry either a data byte or an end-of-stream flush. Data bytes
// whose position modulo four is enabled by the lane mask are buffered; the
// request that fills a record of RECORD_LENGTH bytes produces that record
// as a burst of response bytes: count, address, type, data and checksum,
// each with its two ASCII hex digits and begin and finish marks. A flush
// sends any partial record, the optional start record and the end record,
// then clears the stream position, fill count and running address.
// Requests that produce no response are taken every cycle. A request that
// produces a burst is followed by one response byte per cycle, in all
// RECORD_LENGTH + 5 bytes for a full record and up to RECORD_LENGTH + 14
// for a flush; the microcode sequencer emits one byte per step and takes
// no new request until the burst is handed off. The last byte of a burst
// is marked with last. A stalled receiver holds the response register and
// freezes the sequencer. Reset clears the stream state and loads the
// register defaults; the buffer needs no clearing.
module hex_record_encoder #(
   parameter int RECORD_LENGTH = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   hre_req_if.sink                         req_ch,
   hre_rsp_if.source                       rsp_ch,
   input  logic                            csr_write_en,
   input  logic [hre_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [hre_pkg::CSR_DATA_W-1:0]  csr_data
);
   import hre_pkg::*;

   seq_ctrl_type  ctrl;
   dp_status_type status;

   hre_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   hre_dpath #(
      .RECORD_LENGTH (RECORD_LENGTH)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .req          (req_ch),
      .rsp          (rsp_ch),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .ctrl         (ctrl),
      .status       (status)
   );

endmodule

// ===== dv/hex_record_encoder_test.sv =====
// Self-checking testbench of the hex record encoder with directed and random requests.
module hex_record_encoder_test;
   timeunit 1ns;
   timeprecision 1ps;

   import hre_pkg::*;

   localparam int REC_LEN         = 16;
   localparam int HOLD_CYCLES     = 300;
   localparam int RANDOM_REQUESTS = 410;
   localparam int IDLE_PERCENT    = 6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 3'd6;
   localparam logic [6:0] ASCII_ZERO = 7'h30;
   localparam logic [6:0] ASCII_A    = 7'h41;

   typedef struct packed {
      logic [7:0] value;
      logic [6:0] high_char;
      logic [6:0] low_char;
      logic       rec_begin;
      logic       rec_finish;
      logic       is_last;
   } hex_byte_type;

   class hex_scoreboard;
      logic [3:0]  lane_mask;
      logic [15:0] addr_offset;
      logic [15:0] start_addr;
      logic        start_en;
      logic [1:0]  lane_pos;
      logic [7:0]  line_buf [REC_LEN];
      int          fill;
      logic [15:0] base_addr;
      hex_byte_type expected_bytes [$];
      int          errors;
      int          checked;
      int          records;
      int          requests;

      function new();
         lane_mask = 4'hF;
         addr_offset = 16'h0000;
         start_addr = 16'h0000;
         start_en = 1'b0;
         lane_pos = 2'd0;
         fill = 0;
         base_addr = 16'h0000;
      endfunction

      function int pending();
         return expected_bytes.size();
      endfunction

      function logic [6:0] ascii_digit(input logic [3:0] nib);
         return (nib < 4'd10) ? ASCII_ZERO + {3'b000, nib} : ASCII_A + {3'b000, nib} - 7'd10;
      endfunction

      function void push_byte(input logic [7:0] value, input logic first, input logic closing);
         hex_byte_type b;
         b.value = value;
         b.high_char = ascii_digit(value[7:4]);
         b.low_char = ascii_digit(value[3:0]);
         b.rec_begin = first;
         b.rec_finish = closing;
         b.is_last = 1'b0;
         expected_bytes.push_back(b);
      endfunction

      function void push_record(input logic [7:0] count, input logic [15:0] addr,
                                input logic [7:0] kind, input bit with_data);
         logic [7:0] sum;
         sum = count + addr[15:8] + addr[7:0] + kind;
         push_byte(count, 1'b1, 1'b0);
         push_byte(addr[15:8], 1'b0, 1'b0);
         push_byte(addr[7:0], 1'b0, 1'b0);
         push_byte(kind, 1'b0, 1'b0);
         if (with_data) begin
            for (int i = 0; i < count; i++) begin
               sum += line_buf[i];
               push_byte(line_buf[i], 1'b0, 1'b0);
            end
         end
         push_byte(~sum + 8'd1, 1'b0, 1'b1);
         records++;
      endfunction

      function void note_request(input logic func, input logic [7:0] data);
         int         queued;
         logic [3:0] mask;
         queued = expected_bytes.size();
         requests++;
         if (func == FUNC_DATA) begin
            mask = (lane_mask == 4'h0) ? 4'hF : lane_mask;
            if (mask[lane_pos]) begin
               line_buf[fill] = data;
               fill++;
               if (fill == REC_LEN) begin
                  push_record(8'(REC_LEN), base_addr + addr_offset, 8'(REC_DATA), 1'b1);
                  base_addr += 16'(REC_LEN);
                  fill = 0;
               end
            end
            lane_pos++;
         end else begin
            if (fill != 0)
               push_record(8'(fill), base_addr + addr_offset, 8'(REC_DATA), 1'b1);
            if (start_en)
               push_record(8'd0, start_addr, 8'(REC_START), 1'b0);
            push_record(8'd0, 16'h0000, 8'(REC_EOF), 1'b0);
            lane_pos = 2'd0;
            fill = 0;
            base_addr = 16'h0000;
         end
         if (expected_bytes.size() > queued)
            expected_bytes[expected_bytes.size() - 1].is_last = 1'b1;
      endfunction

      function void compare_field(input string name, input logic [7:0] want,
                                  input logic [7:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         end
      endfunction

      function void check_response(input hex_byte_type got);
         hex_byte_type want;
         if (expected_bytes.size() == 0) begin
            errors++;
            $display("%0t: unexpected response, expected nothing, actual %h", $time, got);
            return;
         end
         want = expected_bytes.pop_front();
         checked++;
         compare_field("record_byte", want.value, got.value);
         compare_field("hex_high_char", 8'(want.high_char), 8'(got.high_char));
         compare_field("hex_low_char", 8'(want.low_char), 8'(got.low_char));
         compare_field("record_begin", 8'(want.rec_begin), 8'(got.rec_begin));
         compare_field("record_finish", 8'(want.rec_finish), 8'(got.rec_finish));
         compare_field("last", 8'(want.is_last), 8'(got.is_last));
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;
   bit                     quiet;
   bit                     hold_request;
   int                     setting_count;
   hex_scoreboard          sb = new();

   hre_req_if req_bus ();
   hre_rsp_if rsp_bus ();

   hex_record_encoder #(.RECORD_LENGTH(REC_LEN)) uut (
      .clock        (clock),
      .reset        (reset),
      .req_ch       (req_bus),
      .rsp_ch       (rsp_bus),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready)
            sb.check_response('{rsp_bus.record_byte, rsp_bus.hex_high_char,
                                rsp_bus.hex_low_char, rsp_bus.record_begin,
                                rsp_bus.record_finish, rsp_bus.last});
         if (req_bus.valid && req_bus.ready)
            sb.note_request(req_bus.func, req_bus.data_byte);
      end
   end

   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_bus.ready <= quiet || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   task automatic send_request(input logic func, input logic [7:0] data);
      if (!quiet && $urandom_range(99) < IDLE_PERCENT) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.func <= func;
      req_bus.data_byte <= data;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   task automatic quiesce();
      req_bus.valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic program_registers(input logic [3:0] mask, input logic [15:0] offset,
                                    input logic [15:0] start, input logic enable);
      csr_write_en <= 1'b1;
      csr_index <= CSR_LANE_MASK;
      csr_data <= {12'h000, mask};
      @(negedge clock);
      csr_index <= CSR_ADDR_OFFSET;
      csr_data <= offset;
      @(negedge clock);
      csr_index <= CSR_START_ADDR;
      csr_data <= start;
      @(negedge clock);
      csr_index <= CSR_START_ENABLE;
      csr_data <= {15'h0000, enable};
      @(negedge clock);
      csr_index <= CSR_SPARE;
      csr_data <= 16'($urandom);
      @(negedge clock);
      csr_write_en <= 1'b0;
      sb.lane_mask = mask;
      sb.addr_offset = offset;
      sb.start_addr = start;
      sb.start_en = enable;
      setting_count++;
   endtask

   function automatic logic [15:0] pick_word();
      case ($urandom_range(3))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [3:0] pick_mask();
      case ($urandom_range(3))
         0: return 4'h0;
         1: return 4'hF;
         default: return 4'($urandom);
      endcase
   endfunction

   initial begin
      int phase;
      int run;
      req_bus.valid = 1'b0;
      req_bus.func = FUNC_DATA;
      req_bus.data_byte = 8'h00;
      csr_write_en = 1'b0;
      csr_index = CSR_LANE_MASK;
      csr_data = 16'h0000;
      reset = 1'b1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // An empty stream produces only the end record.
      send_request(FUNC_FLUSH, 8'h00);
      quiesce();

      // A zero mask keeps every lane; the second record address wraps past 16 bits.
      program_registers(4'h0, 16'hFFF8, 16'hFFFF, 1'b1);
      send_request(FUNC_DATA, 8'h00);
      send_request(FUNC_DATA, 8'hFF);
      send_request(FUNC_DATA, 8'h80);
      send_request(FUNC_DATA, 8'h01);
      send_request(FUNC_DATA, 8'h7F);
      send_request(FUNC_DATA, 8'hFE);
      for (int i = 0; i < REC_LEN - 6; i++)
         send_request(FUNC_DATA, 8'($urandom));
      send_request(FUNC_DATA, 8'hAA);
      send_request(FUNC_DATA, 8'h55);
      send_request(FUNC_FLUSH, 8'hFF);
      quiesce();

      // Only lane zero is kept, so two of these bytes are dropped.
      program_registers(4'b0001, 16'h0000, 16'h0000, 1'b0);
      send_request(FUNC_DATA, 8'h3C);
      send_request(FUNC_DATA, 8'hC3);
      send_request(FUNC_DATA, 8'h99);
      send_request(FUNC_FLUSH, 8'h00);
      quiesce();

      phase = 0;
      while (sb.requests < RANDOM_REQUESTS) begin
         quiet = (phase == 2);
         if (phase == 3) begin
            program_registers(4'hF, pick_word(), pick_word(), 1'($urandom));
            hold_request = 1'b1;
            run = 3 * REC_LEN;
         end else begin
            program_registers(pick_mask(), pick_word(), pick_word(), 1'($urandom));
            if (quiet)
               run = 5 * REC_LEN;
            else
               run = ($urandom_range(2) == 0) ? $urandom_range(20, 70) : $urandom_range(1, 20);
         end
         for (int i = 0; i < run; i++)
            send_request(FUNC_DATA, 8'($urandom_range(255)));
         if ($urandom_range(9) != 0)
            send_request(FUNC_FLUSH, 8'($urandom));
         if ($urandom_range(7) == 0)
            send_request(FUNC_FLUSH, 8'($urandom));
         quiesce();
         phase++;
      end

      quiet = 1'b0;
      repeat (20) @(negedge clock);
      $display("Sent %0d requests under %0d register settings, including a long receiver hold.",
               sb.requests, setting_count);
      $display("Checked %0d response bytes forming %0d records.", sb.checked, sb.records);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("*** PASSED ***");
      end else begin
         if (sb.pending() != 0)
            $display("%0t: %0d expected response bytes never arrived", $time, sb.pending());
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #1_000_000;
      $display("Timeout with %0d response bytes outstanding.", sb.pending());
      $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/hre_pkg.sv
hw/rtl/hre_if.sv
hw/rtl/hre_ram.sv
hw/rtl/hre_seq.sv
hw/rtl/hre_dpath.sv
hw/rtl/hex_record_encoder.sv
dv/hex_record_encoder_test.sv
